@@ sv/tagdf_pkg.sv @@
package tagdf_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TAG_CODE_W = 10;
    localparam int unsigned SHORT_W    = 6;
    localparam int unsigned TAG_LEN_W  = 32;

    // short length value that announces a 32-bit length after the header
    localparam logic [SHORT_W-1:0] SHORT_LEN_ESC = 6'h3F;

endpackage

@@ sv/tag_record_deframer.sv @@
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+------------------------------------------
// input   | in        | i_valid / o_stall         | i_in_byte, i_end_of_file
// result  | out       | o_valid / i_stall         | o_tag_code, o_long_form, o_tag_length,
//         |           |                           | o_payload_byte, o_byte_valid, o_tag_end,
//         |           |                           | o_truncated
//
// One input item per cycle while o_stall is low; its result (if any) is written to the output register.
// Throughput is set by the single output register: a new item is taken whenever that register
// is empty or its item is taken in the same cycle.
// Synchronous active-low reset returns the parser to the first header byte and empties the
// output register. An item flagged end of file also returns the parser to that state.
// o_stall is high only while a result is held and i_stall is high.
module tag_record_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [tagdf_pkg::BYTE_W-1:0]        i_in_byte,
    input  logic                                i_end_of_file,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tagdf_pkg::TAG_CODE_W-1:0]    o_tag_code,
    output logic                                o_long_form,
    output logic [tagdf_pkg::TAG_LEN_W-1:0]     o_tag_length,
    output logic [tagdf_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic                                o_byte_valid,
    output logic                                o_tag_end,
    output logic                                o_truncated
);

    typedef enum logic [2:0] {
        PH_H0  = 3'd0,
        PH_H1  = 3'd1,
        PH_L0  = 3'd2,
        PH_L1  = 3'd3,
        PH_L2  = 3'd4,
        PH_L3  = 3'd5,
        PH_PAY = 3'd6
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [tagdf_pkg::BYTE_W-1:0]        r_hdr_low, n_hdr_low;
    logic [tagdf_pkg::TAG_CODE_W-1:0]    r_code, n_code;
    logic [tagdf_pkg::TAG_LEN_W-1:0]     r_len, n_len;
    logic [tagdf_pkg::TAG_LEN_W-1:0]     r_left, n_left;
    logic                                r_long, n_long;

    logic                                r_out_valid;
    logic [tagdf_pkg::TAG_CODE_W-1:0]    r_out_code;
    logic                                r_out_long;
    logic [tagdf_pkg::TAG_LEN_W-1:0]     r_out_len;
    logic [tagdf_pkg::BYTE_W-1:0]        r_out_pb;
    logic                                r_out_bv;
    logic                                r_out_end;
    logic                                r_out_trunc;

    logic                                in_acc;
    logic [2*tagdf_pkg::BYTE_W-1:0]      hdr;
    logic [tagdf_pkg::SHORT_W-1:0]       short_len;
    logic [tagdf_pkg::TAG_LEN_W-1:0]     full_len;

    logic                                res_valid;
    logic [tagdf_pkg::TAG_LEN_W-1:0]     res_len;
    logic [tagdf_pkg::BYTE_W-1:0]        res_pb;
    logic                                res_bv;
    logic                                res_end;
    logic                                res_trunc;

    assign o_stall   = r_out_valid & i_stall;
    assign in_acc    = i_valid & ~o_stall;
    assign hdr       = {i_in_byte, r_hdr_low};
    assign short_len = hdr[tagdf_pkg::SHORT_W-1:0];
    assign full_len  = {i_in_byte, r_len[tagdf_pkg::TAG_LEN_W-tagdf_pkg::BYTE_W-1:0]};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_low = r_hdr_low;
        n_code    = r_code;
        n_len     = r_len;
        n_left    = r_left;
        n_long    = r_long;
        res_valid = 1'b0;
        res_len   = '0;
        res_pb    = '0;
        res_bv    = 1'b0;
        res_end   = 1'b0;
        res_trunc = 1'b0;

        case (r_phase)
            PH_H1: begin
                n_code = hdr[2*tagdf_pkg::BYTE_W-1:tagdf_pkg::SHORT_W];
                if (short_len == tagdf_pkg::SHORT_LEN_ESC) begin
                    n_long  = 1'b1;
                    n_len   = '0;
                    n_phase = PH_L0;
                    if (i_end_of_file) begin
                        res_valid = 1'b1;
                        res_end   = 1'b1;
                        res_trunc = 1'b1;
                    end
                end else begin
                    n_long = 1'b0;
                    n_len  = tagdf_pkg::TAG_LEN_W'(short_len);
                    if (short_len == '0) begin
                        res_valid = 1'b1;
                        res_end   = 1'b1;
                        n_phase   = PH_H0;
                    end else begin
                        n_left  = tagdf_pkg::TAG_LEN_W'(short_len);
                        n_phase = PH_PAY;
                        if (i_end_of_file) begin
                            res_valid = 1'b1;
                            res_len   = tagdf_pkg::TAG_LEN_W'(short_len);
                            res_end   = 1'b1;
                            res_trunc = 1'b1;
                        end
                    end
                end
            end
            PH_L0, PH_L1, PH_L2: begin
                case (r_phase)
                    PH_L0:   n_len[7:0]   = i_in_byte;
                    PH_L1:   n_len[15:8]  = i_in_byte;
                    default: n_len[23:16] = i_in_byte;
                endcase
                n_phase = t_phase'(r_phase + 3'd1);
                if (i_end_of_file) begin
                    res_valid = 1'b1;
                    res_end   = 1'b1;
                    res_trunc = 1'b1;
                end
            end
            PH_L3: begin
                n_len = full_len;
                if (full_len == '0) begin
                    res_valid = 1'b1;
                    res_end   = 1'b1;
                    n_phase   = PH_H0;
                end else begin
                    n_left  = full_len;
                    n_phase = PH_PAY;
                    if (i_end_of_file) begin
                        res_valid = 1'b1;
                        res_len   = full_len;
                        res_end   = 1'b1;
                        res_trunc = 1'b1;
                    end
                end
            end
            PH_PAY: begin
                n_left    = r_left - tagdf_pkg::TAG_LEN_W'(1);
                res_valid = 1'b1;
                res_len   = r_len;
                res_pb    = i_in_byte;
                res_bv    = 1'b1;
                if (r_left == tagdf_pkg::TAG_LEN_W'(1)) begin
                    res_end = 1'b1;
                    n_phase = PH_H0;
                end else begin
                    res_end   = i_end_of_file;
                    res_trunc = i_end_of_file;
                end
            end
            default: begin
                n_hdr_low = i_in_byte;
                n_phase   = PH_H1;
                if (i_end_of_file) begin
                    n_code    = '0;
                    n_long    = 1'b0;
                    res_valid = 1'b1;
                    res_end   = 1'b1;
                    res_trunc = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_H0;
            r_hdr_low   <= '0;
            r_code      <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_long      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_out_valid <= res_valid;
                // end of file: the next byte starts a fresh file
                if (i_end_of_file) begin
                    r_phase   <= PH_H0;
                    r_hdr_low <= '0;
                    r_code    <= '0;
                    r_len     <= '0;
                    r_left    <= '0;
                    r_long    <= 1'b0;
                end else begin
                    r_phase   <= n_phase;
                    r_hdr_low <= n_hdr_low;
                    r_code    <= n_code;
                    r_len     <= n_len;
                    r_left    <= n_left;
                    r_long    <= n_long;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_code  <= n_code;
            r_out_long  <= n_long;
            r_out_len   <= res_len;
            r_out_pb    <= res_pb;
            r_out_bv    <= res_bv;
            r_out_end   <= res_end;
            r_out_trunc <= res_trunc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tag_code     = r_out_code;
    assign o_long_form    = r_out_long;
    assign o_tag_length   = r_out_len;
    assign o_payload_byte = r_out_pb;
    assign o_byte_valid   = r_out_bv;
    assign o_tag_end      = r_out_end;
    assign o_truncated    = r_out_trunc;

endmodule

@@ sv/tagdf_checker.sv @@
module tagdf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                i_end_of_file,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [tagdf_pkg::TAG_CODE_W-1:0]    o_tag_code,
    input logic                                o_long_form,
    input logic [tagdf_pkg::TAG_LEN_W-1:0]     o_tag_length,
    input logic [tagdf_pkg::BYTE_W-1:0]        o_payload_byte,
    input logic                                o_byte_valid,
    input logic                                o_tag_end,
    input logic                                o_truncated
);

    // a held result does not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tag_code) && $stable(o_tag_length)
            && $stable(o_payload_byte) && $stable(o_tag_end) && $stable(o_truncated))
        else $error("held result changed");

    // every end-of-file item closes a tag
    a_eof_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_end_of_file |=> o_valid && o_tag_end)
        else $error("end of file gave no closing result");

    a_trunc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_tag_end)
        else $error("truncated without tag end");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_payload_byte == '0)
        else $error("payload byte set without byte valid");

    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_long_form |->
            o_tag_length < tagdf_pkg::TAG_LEN_W'(tagdf_pkg::SHORT_LEN_ESC))
        else $error("short form length out of range");

endmodule

bind tag_record_deframer tagdf_checker u_tagdf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_end_of_file  (i_end_of_file),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_tag_code     (o_tag_code),
    .o_long_form    (o_long_form),
    .o_tag_length   (o_tag_length),
    .o_payload_byte (o_payload_byte),
    .o_byte_valid   (o_byte_valid),
    .o_tag_end      (o_tag_end),
    .o_truncated    (o_truncated)
);
